@@ rtl/core/alpha_over_blend_unit_assert.svh @@
// assertion macros for the blend unit rtl
`ifndef ALPHA_OVER_BLEND_UNIT_ASSERT_SVH
`define ALPHA_OVER_BLEND_UNIT_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define AOB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define AOB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/aob_pkg.sv @@
`timescale 1ns / 1ps
package aob_pkg;

  localparam int unsigned COORD_W = 12;
  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned DEN_W   = 16;
  localparam int unsigned NUM_W   = 24;
  localparam int unsigned NCHAN   = 3;
  localparam int unsigned QUO_W   = 8;

  // floor(x / 255) == (x * 32897) >> 23 for every x below 2**16
  localparam logic [31:0] RECIP_255   = 32'd32897;
  localparam int unsigned RECIP_SHIFT = 23;

  typedef struct packed {
    logic [COORD_W-1:0]            x;
    logic [COORD_W-1:0]            y;
    logic [NCHAN-1:0][CHAN_W-1:0]  src;
    logic [NCHAN-1:0][CHAN_W-1:0]  dst;
    logic [CHAN_W-1:0]             sa;
    logic [CHAN_W-1:0]             da;
  } aob_pix_t;

  typedef struct packed {
    logic [COORD_W-1:0]            x;
    logic [COORD_W-1:0]            y;
    logic [DEN_W-1:0]              den;
    logic [DEN_W-1:0]              wd;
    logic [NCHAN-1:0][DEN_W-1:0]   ps;
    logic [NCHAN-1:0][CHAN_W-1:0]  dc;
  } aob_prod_t;

  typedef struct packed {
    logic [COORD_W-1:0]            x;
    logic [COORD_W-1:0]            y;
    logic [DEN_W-1:0]              den;
    logic [CHAN_W-1:0]             alpha;
    logic [NCHAN-1:0][NUM_W-1:0]   rem;
    logic [NCHAN-1:0][QUO_W-1:0]   quo;
  } aob_div_t;

endpackage

@@ rtl/core/aob_premul.sv @@
`timescale 1ns / 1ps
module aob_premul (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  aob_pkg::aob_pix_t pix,
  output logic             mid_valid,
  input  logic             mid_ready,
  output aob_pkg::aob_div_t mid
);

  localparam int unsigned CHAN_W_LOC = aob_pkg::CHAN_W;

  logic              v1;
  aob_pkg::aob_prod_t p1;
  aob_pkg::aob_prod_t p1_next;
  logic              en1;
  logic              en2;
  aob_pkg::aob_div_t mid_next;
  logic [31:0]       alpha_prod;

  assign en2      = !mid_valid || mid_ready;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  // stage 1: alpha weights and source products
  always_comb begin
    logic [CHAN_W_LOC-1:0] ia;
    ia            = 8'hFF - pix.sa;
    p1_next.x     = pix.x;
    p1_next.y     = pix.y;
    p1_next.wd    = 16'(ia) * 16'(pix.da);
    p1_next.den   = ({pix.sa, 8'h00} - {8'h00, pix.sa}) + p1_next.wd;
    for (int c = 0; c < aob_pkg::NCHAN; c++) begin
      p1_next.ps[c] = 16'(pix.src[c]) * 16'(pix.sa);
      p1_next.dc[c] = pix.dst[c];
    end
  end

  // stage 2: channel numerators and output alpha
  assign alpha_prod = 32'(p1.den) * aob_pkg::RECIP_255;

  always_comb begin
    mid_next.x     = p1.x;
    mid_next.y     = p1.y;
    mid_next.den   = p1.den;
    mid_next.alpha = alpha_prod[aob_pkg::RECIP_SHIFT +: aob_pkg::CHAN_W];
    mid_next.quo   = '0;
    for (int c = 0; c < aob_pkg::NCHAN; c++) begin
      mid_next.rem[c] = ({p1.ps[c], 8'h00} - 24'(p1.ps[c]))
                      + 24'(p1.wd) * 24'(p1.dc[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      mid_valid <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) mid_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_valid) p1 <= p1_next;
    if (en2 && v1) mid <= mid_next;
  end

endmodule

@@ rtl/core/aob_divider.sv @@
`timescale 1ns / 1ps
module aob_divider (
  input  logic              clk,
  input  logic              rst,
  input  logic              mid_valid,
  output logic              mid_ready,
  input  aob_pkg::aob_div_t mid,
  output logic              res_valid,
  input  logic              res_ready,
  output aob_pkg::aob_div_t res
);

  localparam int unsigned NST = aob_pkg::QUO_W;

  logic              v  [NST];
  logic              en [NST];
  aob_pkg::aob_div_t st [NST];

  assign mid_ready = en[0];
  assign res_valid = v[NST-1];
  assign res       = st[NST-1];

  genvar k;
  generate
    for (k = 0; k < NST; k++) begin : g_stage
      logic              up_v;
      aob_pkg::aob_div_t up;
      aob_pkg::aob_div_t nxt;

      if (k == 0) begin : g_first
        assign up_v = mid_valid;
        assign up   = mid;
      end else begin : g_rest
        assign up_v = v[k-1];
        assign up   = st[k-1];
      end

      if (k == NST-1) begin : g_last
        assign en[k] = !v[k] || res_ready;
      end else begin : g_mid
        assign en[k] = !v[k] || en[k+1];
      end

      // one restoring step per channel, quotient bit NST-1-k
      always_comb begin
        logic [aob_pkg::NUM_W-1:0] dsh;
        dsh = aob_pkg::NUM_W'(up.den) << (NST - 1 - k);
        nxt = up;
        for (int c = 0; c < aob_pkg::NCHAN; c++) begin
          if (up.rem[c] >= dsh) begin
            nxt.rem[c]             = up.rem[c] - dsh;
            nxt.quo[c][NST - 1 - k] = 1'b1;
          end
        end
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          v[k] <= 1'b0;
        end else if (en[k]) begin
          v[k] <= up_v;
        end
      end

      always_ff @(posedge clk) begin
        if (en[k] && up_v) st[k] <= nxt;
      end
    end
  endgenerate

endmodule

@@ rtl/core/alpha_over_blend_unit.sv @@
`timescale 1ns / 1ps
// 2 product stages plus 8 divide stages from input transfer to result valid
// one pixel per clock unless the output stalls; 8-stage restoring divider, one quotient bit a stage
// each stage holds its own valid bit, so bubbles are squeezed out while the output stalls
// reset: synchronous active-high rst clears all valid bits, pixel data registers are not reset
`include "alpha_over_blend_unit_assert.svh"
module alpha_over_blend_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [11:0] pos_x,
  input  logic [11:0] pos_y,
  input  logic [7:0]  src_red,
  input  logic [7:0]  src_green,
  input  logic [7:0]  src_blue,
  input  logic [7:0]  src_alpha,
  input  logic [7:0]  dst_red,
  input  logic [7:0]  dst_green,
  input  logic [7:0]  dst_blue,
  input  logic [7:0]  dst_alpha,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [11:0] out_x,
  output logic [11:0] out_y,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_alpha
);

  aob_pkg::aob_pix_t pix;
  logic              mid_valid;
  logic              mid_ready;
  aob_pkg::aob_div_t mid;
  aob_pkg::aob_div_t res;
  logic              den_zero;
  logic              rem_in_range;

  // gather the input pixel, channel order red, green, blue
  always_comb begin
    pix.x      = pos_x;
    pix.y      = pos_y;
    pix.src[0] = src_red;
    pix.src[1] = src_green;
    pix.src[2] = src_blue;
    pix.dst[0] = dst_red;
    pix.dst[1] = dst_green;
    pix.dst[2] = dst_blue;
    pix.sa     = src_alpha;
    pix.da     = dst_alpha;
  end

  // weights, numerators and output alpha
  aob_premul u_premul (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .pix       (pix),
    .mid_valid (mid_valid),
    .mid_ready (mid_ready),
    .mid       (mid)
  );

  // per-channel numerator / combined coverage, last stage is the output register
  aob_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .mid_valid (mid_valid),
    .mid_ready (mid_ready),
    .mid       (mid),
    .res_valid (out_valid),
    .res_ready (out_ready),
    .res       (res)
  );

  // both alphas zero: fully transparent result, colors forced to zero
  assign den_zero  = (res.den == '0);
  assign out_x     = res.x;
  assign out_y     = res.y;
  assign out_red   = den_zero ? '0 : res.quo[0];
  assign out_green = den_zero ? '0 : res.quo[1];
  assign out_blue  = den_zero ? '0 : res.quo[2];
  assign out_alpha = res.alpha;

  // every channel remainder left below the divisor
  assign rem_in_range = (res.rem[0] < 24'(res.den)) && (res.rem[1] < 24'(res.den))
                     && (res.rem[2] < 24'(res.den));

  // input can only back up when every stage is full and the output is stalled
  `AOB_ASSERT_NOW(a_full_when_blocked, !in_ready, out_valid && !out_ready, "input blocked without full pipe")
  // an internal transfer held back keeps its data
  `AOB_ASSERT_NEXT(a_mid_hold, mid_valid && !mid_ready, mid_valid && $stable(mid), "mid stage lost data")
  // remainder after the last quotient bit is below the divisor
  `AOB_ASSERT_NOW(a_rem_below_den, out_valid && !den_zero, rem_in_range, "divider remainder out of range")

endmodule
